### hdl/rrw_pkg.sv
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared types and codes of the receive reorder window: the request and
// result items and the opcode and status codes.
// ----------------------------------------------------------------------------
package rrw_pkg;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 12;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int FILL_W = 17;

    // request opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTWIN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [SEQ_W-1:0] seq_num;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] seg_tag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              deliver_valid;
        logic [TAG_W-1:0]  deliver_tag;
        logic [LEN_W-1:0]  deliver_len;
        logic [LEN_W-1:0]  bytes_read;
        logic [SEQ_W-1:0]  window_begin;
        logic [SEQ_W-1:0]  window_end;
        logic [FILL_W-1:0] buffer_fill;
        logic              last;
    } rsp_t;

endpackage

### hdl/rrw_if.sv
// ----------------------------------------------------------------------------
// rrw_if
// Valid/ready channels of the receive reorder window: request and result.
// ----------------------------------------------------------------------------
interface rrw_req_if;
    logic          valid;
    logic          ready;
    rrw_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrw_rsp_if;
    logic          valid;
    logic          ready;
    rrw_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/reorder_receive_window.sv
// A read, reject or duplicate gives one result: the request is registered, decided
// in S_EXEC, and the result is registered and shown in S_OUT. A store writes its
// slot in S_EXEC, then loops through S_FETCH (slot memory read), S_CHECK (buffer
// check) and S_OUT (one delivery result) until a hole or a full buffer gives the
// closing result. One request at a time: the next is taken after the closing
// result is accepted. Reset: control state and slot occupancy clear at once.
// ----------------------------------------------------------------------------
// reorder_receive_window
// Selective-repeat receive window: stores out-of-order segments in slots and
// drains them in order into a byte buffer, one slot per step of a small
// sequencer; read requests pop bytes from that buffer.
// ----------------------------------------------------------------------------
module reorder_receive_window #(
    parameter int WINDOW    = 16,
    parameter int BUF_BYTES = 65536,
    parameter int MAX_SEG   = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    rrw_req_if.sink         req,
    rrw_rsp_if.source       rsp
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(BUF_BYTES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_CHECK = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic [rrw_pkg::LEN_W-1:0] len;
        logic [rrw_pkg::TAG_W-1:0] tag;
    } slot_t;

    typedef struct packed {
        logic [rrw_pkg::STAT_W-1:0] status;
        logic                       deliver_valid;
        logic [rrw_pkg::TAG_W-1:0]  deliver_tag;
        logic [rrw_pkg::LEN_W-1:0]  deliver_len;
        logic [rrw_pkg::LEN_W-1:0]  bytes_read;
        logic                       last;
    } res_t;

    state_t                    state_reg, state_next;
    rrw_pkg::req_t             item_reg, item_next;
    logic [rrw_pkg::SEQ_W-1:0] begin_reg, begin_next;
    logic [IW-1:0]             bidx_reg, bidx_next;
    logic [WINDOW-1:0]         full_reg, full_next;
    logic [FW-1:0]             fill_reg, fill_next;
    res_t                      res_reg, res_next;
    slot_t                     slot_rd_reg;
    slot_t                     slot_mem [WINDOW];

    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    slot_t                     mem_wdata;

    logic [rrw_pkg::SEQ_W-1:0] seq_gap;
    logic                      in_win;
    logic [IW:0]               idx_sum;
    logic [IW-1:0]             idx;
    logic [rrw_pkg::LEN_W-1:0] len_sat;
    logic [rrw_pkg::LEN_W-1:0] take;
    logic [FW:0]               drain_sum;
    logic [IW-1:0]             bidx_inc;
    logic [FW+16:0]            fill_ext;

    // window test and slot index of the arriving segment
    assign seq_gap = item_reg.seq_num - begin_reg;
    assign in_win  = seq_gap < rrw_pkg::SEQ_W'(WINDOW);
    assign idx_sum = {1'b0, bidx_reg} + {1'b0, seq_gap[IW-1:0]};
    assign idx     = (idx_sum >= (IW+1)'(WINDOW)) ? IW'(idx_sum - (IW+1)'(WINDOW))
                                                  : idx_sum[IW-1:0];

    // clamp oversize segments
    assign len_sat = (32'(item_reg.length) > 32'(MAX_SEG)) ? rrw_pkg::LEN_W'(MAX_SEG)
                                                           : item_reg.length;

    // bytes popped by a read
    assign take = (FW'(item_reg.length) < fill_reg) ? item_reg.length
                                                    : fill_reg[rrw_pkg::LEN_W-1:0];

    // buffer room check for the slot at the window start
    assign drain_sum = {1'b0, fill_reg} + (FW+1)'(slot_rd_reg.len);

    assign bidx_inc = (bidx_reg == IW'(WINDOW - 1)) ? '0 : bidx_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        begin_next = begin_reg;
        bidx_next  = bidx_reg;
        full_next  = full_reg;
        fill_next  = fill_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx;
        mem_wdata  = '{len: len_sat, tag: item_reg.seg_tag};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next = '{status: rrw_pkg::STAT_OK, deliver_valid: 1'b0,
                             deliver_tag: '0, deliver_len: '0, bytes_read: '0,
                             last: 1'b1};
                if (item_reg.opcode == rrw_pkg::OP_READ)
                begin
                    fill_next           = fill_reg - FW'(take);
                    res_next.bytes_read = take;
                    state_next          = S_OUT;
                end
                else if (!in_win)
                begin
                    res_next.status = seq_gap[rrw_pkg::SEQ_W-1] ? rrw_pkg::STAT_DUP
                                                                : rrw_pkg::STAT_NOTWIN;
                    state_next      = S_OUT;
                end
                else if (full_reg[idx])
                begin
                    res_next.status = rrw_pkg::STAT_DUP;
                    state_next      = S_OUT;
                end
                else
                begin
                    mem_we         = 1'b1;
                    full_next[idx] = 1'b1;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // stop at the first empty slot
                if (!full_reg[bidx_reg])
                begin
                    res_next = '{status: rrw_pkg::STAT_OK, deliver_valid: 1'b0,
                                 deliver_tag: '0, deliver_len: '0, bytes_read: '0,
                                 last: 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (drain_sum > (FW+1)'(BUF_BYTES))
                begin
                    res_next = '{status: rrw_pkg::STAT_FULL, deliver_valid: 1'b0,
                                 deliver_tag: '0, deliver_len: '0, bytes_read: '0,
                                 last: 1'b1};
                end
                else
                begin
                    fill_next           = drain_sum[FW-1:0];
                    full_next[bidx_reg] = 1'b0;
                    begin_next          = begin_reg + 1'b1;
                    bidx_next           = bidx_inc;
                    res_next = '{status: rrw_pkg::STAT_OK, deliver_valid: 1'b1,
                                 deliver_tag: slot_rd_reg.tag,
                                 deliver_len: slot_rd_reg.len, bytes_read: '0,
                                 last: 1'b0};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = res_reg.last ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            begin_reg <= '0;
            bidx_reg  <= '0;
            full_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            begin_reg <= begin_next;
            bidx_reg  <= bidx_next;
            full_reg  <= full_next;
            fill_reg  <= fill_next;
        end
    end

    // hold the request and the pending result
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // slot memory: one write port, registered read at the window start
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        slot_rd_reg <= slot_mem[bidx_reg];
    end

    // ports
    assign fill_ext  = {17'b0, fill_reg};
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = '{status:        res_reg.status,
                         deliver_valid: res_reg.deliver_valid,
                         deliver_tag:   res_reg.deliver_tag,
                         deliver_len:   res_reg.deliver_len,
                         bytes_read:    res_reg.bytes_read,
                         window_begin:  begin_reg,
                         window_end:    begin_reg + rrw_pkg::SEQ_W'(WINDOW),
                         buffer_fill:   fill_ext[16:0],
                         last:          res_reg.last};

`ifndef NO_ASSERTIONS
    // never take a request while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while a result is pending");

    // a delivery is never the closing result and always carries status ok
    a_delivery_form: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.deliver_valid) |->
        (!rsp.data.last && rsp.data.status == rrw_pkg::STAT_OK))
        else $error("delivery result marked last or with error status");

    // the byte count stays within the buffer
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(BUF_BYTES))
        else $error("buffer fill exceeds capacity");

    // the window start moves only through a delivery
    a_begin_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (begin_reg != $past(begin_reg)) |-> (rsp.valid && rsp.data.deliver_valid))
        else $error("window start moved without a delivery");
`endif

endmodule

### dv/reorder_receive_window_tb.sv
// ----------------------------------------------------------------------------
// reorder_receive_window_tb
// Self-checking bench for the receive reorder window. A predictor in this
// file tracks slot occupancy, the window start and the buffer byte count,
// and queues the result items each accepted request should produce. The
// bench covers directed cases, buffer overflow and random traffic, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module reorder_receive_window_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = 16;
    localparam int BUF_SIZE   = 65536;
    localparam int SEG_MAX    = 2048;
    localparam int QUIET_MAX  = 3000;
    localparam int SETTLE_CYC = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    rrw_req_if req ();
    rrw_rsp_if rsp ();

    assign rsp.ready = sink_ready;

    reorder_receive_window #(
        .WINDOW    (WIN),
        .BUF_BYTES (BUF_SIZE),
        .MAX_SEG   (SEG_MAX)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // predicted window state
    logic                      slot_busy [WIN];
    logic [rrw_pkg::LEN_W-1:0] slot_bytes[WIN];
    logic [rrw_pkg::TAG_W-1:0] slot_desc [WIN];
    logic [rrw_pkg::SEQ_W-1:0] next_seq = '0;
    int unsigned               held_bytes = 0;

    rrw_pkg::rsp_t due_results[$];
    int   errors = 0;
    int   quiet_cycles = 0;
    bit   gaps_on = 1'b1;
    int   stall_left = 0;

    initial
    begin
        for (int i = 0; i < WIN; i++)
        begin
            slot_busy[i] = 1'b0;
        end
    end

    // queue one result item from the current predicted state
    function automatic void push_result(input logic [rrw_pkg::STAT_W-1:0] st,
                                        input logic dv,
                                        input logic [rrw_pkg::TAG_W-1:0] tag,
                                        input logic [rrw_pkg::LEN_W-1:0] dlen,
                                        input logic [rrw_pkg::LEN_W-1:0] rd,
                                        input logic fin);
        rrw_pkg::rsp_t r;
        r.status        = st;
        r.deliver_valid = dv;
        r.deliver_tag   = tag;
        r.deliver_len   = dlen;
        r.bytes_read    = rd;
        r.window_begin  = next_seq;
        r.window_end    = next_seq + rrw_pkg::SEQ_W'(WIN);
        r.buffer_fill   = rrw_pkg::FILL_W'(held_bytes);
        r.last          = fin;
        due_results.push_back(r);
    endfunction

    // apply one accepted request to the predicted window and queue its results
    function automatic void advance_window(input rrw_pkg::req_t item);
        logic [rrw_pkg::SEQ_W-1:0] seq_gap;
        logic [rrw_pkg::LEN_W-1:0] seg_len;
        int unsigned               take;
        int                        slot;
        if (item.opcode == rrw_pkg::OP_READ)
        begin
            take = (item.length < held_bytes) ? item.length : held_bytes;
            held_bytes -= take;
            push_result(rrw_pkg::STAT_OK, 1'b0, '0, '0, rrw_pkg::LEN_W'(take), 1'b1);
            return;
        end
        seq_gap = item.seq_num - next_seq;
        if (seq_gap >= rrw_pkg::SEQ_W'(WIN))
        begin
            push_result(seq_gap[rrw_pkg::SEQ_W-1] ? rrw_pkg::STAT_DUP : rrw_pkg::STAT_NOTWIN,
                        1'b0, '0, '0, '0, 1'b1);
            return;
        end
        slot = int'(item.seq_num % WIN);
        if (slot_busy[slot])
        begin
            push_result(rrw_pkg::STAT_DUP, 1'b0, '0, '0, '0, 1'b1);
            return;
        end
        // saturate oversize segments and store
        seg_len = (item.length > SEG_MAX) ? rrw_pkg::LEN_W'(SEG_MAX) : item.length;
        slot_busy[slot]  = 1'b1;
        slot_bytes[slot] = seg_len;
        slot_desc[slot]  = item.seg_tag;
        // drain filled slots in order until a hole or a full buffer
        for (int k = 0; k < WIN; k++)
        begin
            slot = int'(next_seq % WIN);
            if (!slot_busy[slot])
                break;
            if (BUF_SIZE - held_bytes < slot_bytes[slot])
            begin
                push_result(rrw_pkg::STAT_FULL, 1'b0, '0, '0, '0, 1'b1);
                return;
            end
            held_bytes += slot_bytes[slot];
            slot_busy[slot] = 1'b0;
            next_seq = next_seq + 1'b1;
            push_result(rrw_pkg::STAT_OK, 1'b1, slot_desc[slot], slot_bytes[slot], '0,
                        1'b0);
        end
        push_result(rrw_pkg::STAT_OK, 1'b0, '0, '0, '0, 1'b1);
    endfunction

    function automatic rrw_pkg::req_t arrive_item(input logic [rrw_pkg::SEQ_W-1:0] seq,
                                                  input int len,
                                                  input logic [rrw_pkg::TAG_W-1:0] tag);
        rrw_pkg::req_t r;
        r.opcode  = rrw_pkg::OP_ARRIVE;
        r.seq_num = seq;
        r.length  = rrw_pkg::LEN_W'(len);
        r.seg_tag = tag;
        return r;
    endfunction

    function automatic rrw_pkg::req_t read_item(input int len);
        rrw_pkg::req_t r;
        r.opcode  = rrw_pkg::OP_READ;
        r.seq_num = $urandom;
        r.length  = rrw_pkg::LEN_W'(len);
        r.seg_tag = $urandom;
        return r;
    endfunction

    // mostly in-window segments, some reads, some out-of-window noise
    function automatic rrw_pkg::req_t random_item(input int read_pct);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < read_pct)
            return read_item(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(1024, 4095));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(SEG_MAX + 1, 4095)
                                          : $urandom_range(0, SEG_MAX);
        if (pick < 88)
            return arrive_item(next_seq + $urandom_range(0, WIN - 1), len, $urandom);
        case ($urandom_range(0, 3))
            0:       return arrive_item($urandom, len, $urandom);
            1:       return arrive_item(next_seq + WIN, len, $urandom);
            2:       return arrive_item(next_seq - $urandom_range(1, 40), len, $urandom);
            default: return arrive_item(next_seq + $urandom_range(WIN + 1, 5000), len,
                                        $urandom);
        endcase
    endfunction

    // send one request item and predict its results once accepted
    task automatic send_item(input rrw_pkg::req_t item);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= item;
        do
            @(posedge clk);
        while (!req.ready);
        advance_window(item);
    endtask

    // drop valid and wait for every predicted result to arrive
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // result-side stalls in bursts of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            sink_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin
        rrw_pkg::rsp_t want;
        rrw_pkg::rsp_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.data;
            if (due_results.size() == 0)
            begin
                $error("unexpected result item: 0x%0h", got);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("deliver_valid", 32'(want.deliver_valid), 32'(got.deliver_valid));
                check_field("deliver_tag", 32'(want.deliver_tag), 32'(got.deliver_tag));
                check_field("deliver_len", 32'(want.deliver_len), 32'(got.deliver_len));
                check_field("bytes_read", 32'(want.bytes_read), 32'(got.bytes_read));
                check_field("window_begin", want.window_begin, got.window_begin);
                check_field("window_end", want.window_end, got.window_end);
                check_field("buffer_fill", 32'(want.buffer_fill), 32'(got.buffer_fill));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_read_empty_buffer();
        send_item(read_item(0));
        send_item(read_item(4095));
    endtask

    // zero length segment, then a gap closed from the far end
    task automatic test_in_order_drain();
        send_item(arrive_item(next_seq, 0, 16'h0000));
        send_item(arrive_item(next_seq + 2, 1000, 16'hFFFF));
        send_item(arrive_item(next_seq + 1, 1, 16'hA5A5));
        send_item(arrive_item(next_seq, 2048, 16'h5A5A));
        send_item(read_item(700));
    endtask

    task automatic test_window_bounds();
        logic [rrw_pkg::SEQ_W-1:0] base;
        base = next_seq;
        send_item(arrive_item(base + WIN - 1, 4095, 16'h8001));
        send_item(arrive_item(base + WIN, 10, 16'h1234));
        send_item(arrive_item(base - 1, 10, 16'h1234));
        send_item(arrive_item(base + 32'h8000_0000, 10, 16'h1234));
        send_item(arrive_item(base + 32'h7FFF_FFFF, 10, 16'h1234));
        send_item(arrive_item(base + WIN - 1, 5, 16'h4321));
        // fill backward so the last store drains the whole window
        for (int i = WIN - 2; i >= 0; i--)
            send_item(arrive_item(base + i, (i == 0) ? 4095 : $urandom_range(0, 600),
                                  $urandom));
    endtask

    task automatic test_buffer_overflow();
        while (held_bytes != 0)
            send_item(read_item(4095));
        for (int i = 0; i < BUF_SIZE / SEG_MAX; i++)
            send_item(arrive_item(next_seq, SEG_MAX, $urandom));
        // a zero length segment still fits in a full buffer
        send_item(arrive_item(next_seq, 0, 16'h0F0F));
        send_item(arrive_item(next_seq + 1, 100, 16'hBEEF));
        send_item(arrive_item(next_seq, SEG_MAX, 16'hCAFE));
        send_item(arrive_item(next_seq, 5, 16'h0001));
        send_item(read_item(1));
        send_item(arrive_item(next_seq + 2, 0, 16'h7777));
        send_item(read_item(4095));
        send_item(arrive_item(next_seq + 3, 7, 16'h3C3C));
        send_item(read_item(4095));
        send_item(read_item(4095));
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            send_item(random_item((i < count / 2) ? 25 : 10));
        end
    endtask

    task automatic test_random_steady(input int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_item(random_item(25));
    endtask

    initial
    begin
        req.valid <= 1'b0;
        req.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_empty_buffer();
        test_in_order_drain();
        test_window_bounds();
        test_buffer_overflow();
        test_random_mix(140);
        test_random_steady(50);

        settle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
